### hdl/lavm_pkg.sv
// Shared types and constants for the look-at view matrix unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package lavm_pkg;

	localparam int UnitOne = 16384;
	localparam int SqrtSteps = 32;
	localparam int DivSteps = 16;

	typedef logic signed [15:0] unit_t;
	typedef logic signed [24:0] trans_t;

endpackage

### hdl/lavm_unitize.sv
// Pipelined normaliser: sum of squares, scale search, square root, three dividers.
// Uses lavm_pkg for the unit type and step counts.
`timescale 1ns / 1ps
module lavm_unitize (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [33:0]  in_cx,
	input  logic signed [33:0]  in_cy,
	input  logic signed [33:0]  in_cz,
	output logic                out_valid,
	output lavm_pkg::unit_t     out_nx,
	output lavm_pkg::unit_t     out_ny,
	output lavm_pkg::unit_t     out_nz
);

	localparam int NS = lavm_pkg::SqrtSteps;
	localparam int ND = lavm_pkg::DivSteps;

	// Stage A: magnitudes and squares.
	logic        va_s1;
	logic [32:0] a_s1 [3];
	logic [2:0]  sg_s1;
	logic [65:0] sq_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) va_s1 <= 1'b0;
		else va_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		logic [33:0] c [3];
		logic [32:0] m;
		c[0] = in_cx; c[1] = in_cy; c[2] = in_cz;
		for (int i = 0; i < 3; i++) begin
			m = c[i][33] ? 33'(-c[i]) : c[i][32:0];
			a_s1[i] <= m;
			sg_s1[i] <= c[i][33];
			sq_s1[i] <= 66'(m) * 66'(m);
		end
	end

	// Stage B: sum and choice of scale k.
	logic        vb_s2;
	logic [32:0] a_s2 [3];
	logic [2:0]  sg_s2;
	logic [63:0] sh_s2;
	logic [3:0]  k_s2;
	logic        z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vb_s2 <= 1'b0;
		else vb_s2 <= va_s1;
	end

	always_ff @(posedge clk) begin
		logic [67:0] s;
		logic [3:0]  k;
		s = 68'(sq_s1[0]) + 68'(sq_s1[1]) + 68'(sq_s1[2]);
		k = 4'd0;
		for (int j = 12; j >= 1; j--) begin
			if (k == 4'd0 && (s >> (62 - 2 * j)) == 68'd0) k = 4'(j);
		end
		a_s2 <= a_s1;
		sg_s2 <= sg_s1;
		k_s2 <= k;
		z_s2 <= (s == 68'd0);
		sh_s2 <= 64'(s << (2 * k));
	end

	// Square root: one result bit per stage.
	logic        vr [NS+1];
	logic [63:0] rv [NS+1];
	logic [63:0] rr [NS+1];
	logic [32:0] ra [NS+1][3];
	logic [2:0]  rs [NS+1];
	logic [3:0]  rk [NS+1];
	logic        rz [NS+1];

	always_comb begin
		vr[0] = vb_s2; rv[0] = sh_s2; rr[0] = '0; ra[0] = a_s2;
		rs[0] = sg_s2; rk[0] = k_s2; rz[0] = z_s2;
	end

	for (genvar g = 0; g < NS; g++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vr[g+1] <= 1'b0;
			else vr[g+1] <= vr[g];
		end
		always_ff @(posedge clk) begin
			logic [63:0] b;
			b = 64'd1 << (62 - 2 * g);
			if (rv[g] >= rr[g] + b) begin
				rv[g+1] <= rv[g] - (rr[g] + b);
				rr[g+1] <= (rr[g] >> 1) + b;
			end else begin
				rv[g+1] <= rv[g];
				rr[g+1] <= rr[g] >> 1;
			end
			ra[g+1] <= ra[g]; rs[g+1] <= rs[g]; rk[g+1] <= rk[g]; rz[g+1] <= rz[g];
		end
	end

	// Division: quotient clamped at 2^14, so 16 restoring steps are enough.
	// Numerator 2*a*2^(14+k), divisor 2m; quotient of (num + m) / (2m).
	logic        vd [ND+1];
	logic [95:0] dn [ND+1][3];
	logic [95:0] dq [ND+1][3];
	logic [33:0] dd [ND+1];
	logic [2:0]  ds [ND+1];
	logic        dz [ND+1];
	logic        dv0;
	logic [95:0] dn0 [3];
	logic [33:0] dd0;
	logic [2:0]  ds0;
	logic        dz0;
	logic [2:0]  big0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv0 <= 1'b0;
		else dv0 <= vr[NS];
	end

	always_ff @(posedge clk) begin
		logic [95:0] num;
		for (int i = 0; i < 3; i++) begin
			num = (96'(ra[NS][i]) << (15 + rk[NS])) + 96'(rr[NS]);
			dn0[i] <= num;
			// Quotient above 2^15 clamps anyway.
			big0[i] <= (num >> 15) >= (96'(rr[NS]) << 1);
		end
		dd0 <= 34'(rr[NS]) << 1;
		ds0 <= rs[NS];
		dz0 <= rz[NS];
	end

	always_comb begin
		vd[0] = dv0; dd[0] = dd0; ds[0] = ds0; dz[0] = dz0;
		for (int i = 0; i < 3; i++) begin
			dn[0][i] = big0[i] ? '0 : dn0[i];
			dq[0][i] = big0[i] ? 96'(lavm_pkg::UnitOne) : '0;
		end
	end

	for (genvar g = 0; g < ND; g++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd[g+1] <= 1'b0;
			else vd[g+1] <= vd[g];
		end
		always_ff @(posedge clk) begin
			logic [95:0] t;
			for (int i = 0; i < 3; i++) begin
				t = 96'(dd[g]) << (ND - 1 - g);
				if (dn[g][i] >= t) begin
					dn[g+1][i] <= dn[g][i] - t;
					dq[g+1][i] <= dq[g][i] | (96'd1 << (ND - 1 - g));
				end else begin
					dn[g+1][i] <= dn[g][i];
					dq[g+1][i] <= dq[g][i];
				end
			end
			dd[g+1] <= dd[g]; ds[g+1] <= ds[g]; dz[g+1] <= dz[g];
		end
	end

	// Clamp, sign and zero-vector handling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= vd[ND];
	end

	always_ff @(posedge clk) begin
		logic [15:0] q [3];
		for (int i = 0; i < 3; i++) begin
			q[i] = (dq[ND][i] > 96'(lavm_pkg::UnitOne)) ? 16'(lavm_pkg::UnitOne)
				: dq[ND][i][15:0];
			if (dz[ND]) q[i] = '0;
			if (ds[ND][i]) q[i] = 16'(-q[i]);
		end
		out_nx <= q[0]; out_ny <= q[1]; out_nz <= q[2];
	end

endmodule

### hdl/lavm_cross.sv
// Registered cross product of a unit vector with a second vector.
// Uses lavm_pkg for the unit type.
`timescale 1ns / 1ps
module lavm_cross (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  lavm_pkg::unit_t    a_x,
	input  lavm_pkg::unit_t    a_y,
	input  lavm_pkg::unit_t    a_z,
	input  logic signed [15:0] b_x,
	input  logic signed [15:0] b_y,
	input  logic signed [15:0] b_z,
	output logic               out_valid,
	output logic signed [33:0] r_x,
	output logic signed [33:0] r_y,
	output logic signed [33:0] r_z
);

	logic               v_s1;
	logic signed [31:0] p_s1 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= a_y * b_z; p_s1[1] <= a_z * b_y;
		p_s1[2] <= a_z * b_x; p_s1[3] <= a_x * b_z;
		p_s1[4] <= a_x * b_y; p_s1[5] <= a_y * b_x;
		r_x <= 34'(p_s1[0]) - 34'(p_s1[1]);
		r_y <= 34'(p_s1[2]) - 34'(p_s1[3]);
		r_z <= 34'(p_s1[4]) - 34'(p_s1[5]);
	end
endmodule

### hdl/lavm_trans.sv
// Dot product with the eye, optional negation, rounding and saturation.
// Uses lavm_pkg for the unit and translation types.
`timescale 1ns / 1ps
module lavm_trans (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               negate,
	input  lavm_pkg::unit_t    u_x,
	input  lavm_pkg::unit_t    u_y,
	input  lavm_pkg::unit_t    u_z,
	input  logic signed [23:0] e_x,
	input  logic signed [23:0] e_y,
	input  logic signed [23:0] e_z,
	output logic               out_valid,
	output lavm_pkg::trans_t   t
);

	logic               v_s1, v_s2;
	logic signed [39:0] p_s1 [3];
	logic signed [41:0] d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [41:0] d;
		logic [41:0] a;
		logic signed [42:0] r;
		for (int i = 0; i < 3; i++) begin
			p_s1[i] <= (i == 0) ? u_x * e_x : (i == 1) ? u_y * e_y : u_z * e_z;
		end
		d = 42'(p_s1[0]) + 42'(p_s1[1]) + 42'(p_s1[2]);
		d_s2 <= negate ? -d : d;
		a = d_s2[41] ? 42'(-d_s2) : d_s2;
		a = (a + 42'd8192) >> 14;
		r = d_s2[41] ? -43'(a) : 43'(a);
		if (r > 43'sd16777215) t <= 25'sd16777215;
		else if (r < -43'sd16777216) t <= -25'sd16777216;
		else t <= r[24:0];
	end
endmodule

### hdl/look_at_view_matrix_unit.sv
// Top level of the look-at view matrix unit.
// Depends on lavm_pkg, lavm_unitize, lavm_cross and lavm_trans.
`timescale 1ns / 1ps
// One item may enter every clock cycle: busy is held low and an item is taken whenever
// start is high. Each item passes three normalisers, two cross-product units and the
// translation units in a fixed pipeline; its result appears on the result ports for one
// cycle with done high, in the order the items went in. The pipeline holds three normalisers
// of 52 stages each (one for the squares, one for the scale, 32 square-root stages, one to
// set up the quotient, 16 quotient stages and one for clamp and sign), two cross-product
// units of two stages each and three translation stages. The receiver cannot hold results
// off, so the result must be captured in the cycle that done is high. A zero-length look
// vector gives an all-zero result; an up hint parallel to look gives zero right and up rows
// and zero right and up translations.
module look_at_view_matrix_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] look_x,
	input  logic signed [15:0] look_y,
	input  logic signed [15:0] look_z,
	input  logic signed [15:0] up_x,
	input  logic signed [15:0] up_y,
	input  logic signed [15:0] up_z,
	input  logic signed [23:0] eye_x,
	input  logic signed [23:0] eye_y,
	input  logic signed [23:0] eye_z,
	output logic               done,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y,
	output logic signed [15:0] right_z,
	output logic signed [15:0] upv_x,
	output logic signed [15:0] upv_y,
	output logic signed [15:0] upv_z,
	output logic signed [15:0] neg_look_x,
	output logic signed [15:0] neg_look_y,
	output logic signed [15:0] neg_look_z,
	output logic signed [24:0] trans_right,
	output logic signed [24:0] trans_up,
	output logic signed [24:0] trans_look
);

	// Latency of one normaliser and of the cross units, used to size delay lines.
	localparam int UL = lavm_pkg::SqrtSteps + lavm_pkg::DivSteps + 4;
	localparam int CL = 2;
	localparam int TL = 3;
	localparam int D1 = UL;          // from input to normalised look
	localparam int D2 = UL + CL + UL; // to normalised right
	localparam int D3 = D2 + CL + UL; // to normalised up

	assign busy = 1'b0;

	// Delay lines for the up hint, matched to the look normaliser, and for the eye, matched to the up normaliser.
	logic [15:0] upd [D1+1][3];
	logic [23:0] eyd [D3+1][3];

	always_comb begin
		upd[0][0] = up_x; upd[0][1] = up_y; upd[0][2] = up_z;
		eyd[0][0] = eye_x; eyd[0][1] = eye_y; eyd[0][2] = eye_z;
	end

	for (genvar g = 0; g < D1; g++) begin : g_upd
		always_ff @(posedge clk) upd[g+1] <= upd[g];
	end
	for (genvar g = 0; g < D3; g++) begin : g_eyd
		always_ff @(posedge clk) eyd[g+1] <= eyd[g];
	end

	// Normalised look.
	logic            lv;
	lavm_pkg::unit_t ln [3];
	lavm_unitize u_look (
		.clk, .arst_n, .in_valid(start),
		.in_cx(34'(look_x)), .in_cy(34'(look_y)), .in_cz(34'(look_z)),
		.out_valid(lv), .out_nx(ln[0]), .out_ny(ln[1]), .out_nz(ln[2])
	);

	// Look delayed to meet the right vector and, further on, the up normaliser output.
	localparam int LD = CL + UL;
	lavm_pkg::unit_t lnd [LD+CL+UL+1][3];
	always_comb lnd[0] = ln;
	for (genvar g = 0; g < LD + CL + UL; g++) begin : g_lnd
		always_ff @(posedge clk) lnd[g+1] <= lnd[g];
	end

	// Right = normalise(L x up).
	logic               rcv;
	logic signed [33:0] rc [3];
	lavm_cross u_rc (
		.clk, .arst_n, .in_valid(lv),
		.a_x(ln[0]), .a_y(ln[1]), .a_z(ln[2]),
		.b_x(upd[D1][0]), .b_y(upd[D1][1]), .b_z(upd[D1][2]),
		.out_valid(rcv), .r_x(rc[0]), .r_y(rc[1]), .r_z(rc[2])
	);

	logic            rv;
	lavm_pkg::unit_t rn [3];
	lavm_unitize u_right (
		.clk, .arst_n, .in_valid(rcv),
		.in_cx(rc[0]), .in_cy(rc[1]), .in_cz(rc[2]),
		.out_valid(rv), .out_nx(rn[0]), .out_ny(rn[1]), .out_nz(rn[2])
	);

	lavm_pkg::unit_t rnd [CL+UL+1][3];
	always_comb rnd[0] = rn;
	for (genvar g = 0; g < CL + UL; g++) begin : g_rnd
		always_ff @(posedge clk) rnd[g+1] <= rnd[g];
	end

	// Up = normalise(R x L).
	logic               ucv;
	logic signed [33:0] uc [3];
	lavm_cross u_uc (
		.clk, .arst_n, .in_valid(rv),
		.a_x(rn[0]), .a_y(rn[1]), .a_z(rn[2]),
		.b_x(lnd[LD][0]), .b_y(lnd[LD][1]), .b_z(lnd[LD][2]),
		.out_valid(ucv), .r_x(uc[0]), .r_y(uc[1]), .r_z(uc[2])
	);

	logic            uv;
	lavm_pkg::unit_t un [3];
	lavm_unitize u_up (
		.clk, .arst_n, .in_valid(ucv),
		.in_cx(uc[0]), .in_cy(uc[1]), .in_cz(uc[2]),
		.out_valid(uv), .out_nx(un[0]), .out_ny(un[1]), .out_nz(un[2])
	);

	// Three translations, all aligned with the up normaliser output.
	logic             tv [3];
	lavm_pkg::trans_t tr [3];
	lavm_trans u_tr (
		.clk, .arst_n, .in_valid(uv), .negate(1'b1),
		.u_x(rnd[CL+UL][0]), .u_y(rnd[CL+UL][1]), .u_z(rnd[CL+UL][2]),
		.e_x(eyd[D3][0]), .e_y(eyd[D3][1]), .e_z(eyd[D3][2]),
		.out_valid(tv[0]), .t(tr[0])
	);
	lavm_trans u_tu (
		.clk, .arst_n, .in_valid(uv), .negate(1'b1),
		.u_x(un[0]), .u_y(un[1]), .u_z(un[2]),
		.e_x(eyd[D3][0]), .e_y(eyd[D3][1]), .e_z(eyd[D3][2]),
		.out_valid(tv[1]), .t(tr[1])
	);
	lavm_trans u_tl (
		.clk, .arst_n, .in_valid(uv), .negate(1'b0),
		.u_x(lnd[LD+CL+UL][0]), .u_y(lnd[LD+CL+UL][1]), .u_z(lnd[LD+CL+UL][2]),
		.e_x(eyd[D3][0]), .e_y(eyd[D3][1]), .e_z(eyd[D3][2]),
		.out_valid(tv[2]), .t(tr[2])
	);

	// Rotation rows delayed to meet the translations.
	lavm_pkg::unit_t rot [TL+1][9];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rot[0][i] = rnd[CL+UL][i];
			rot[0][3+i] = un[i];
			rot[0][6+i] = 16'(-lnd[LD+CL+UL][i]);
		end
	end
	for (genvar g = 0; g < TL; g++) begin : g_rot
		always_ff @(posedge clk) rot[g+1] <= rot[g];
	end

	assign done = tv[0];
	assign right_x = rot[TL][0]; assign right_y = rot[TL][1]; assign right_z = rot[TL][2];
	assign upv_x = rot[TL][3]; assign upv_y = rot[TL][4]; assign upv_z = rot[TL][5];
	assign neg_look_x = rot[TL][6]; assign neg_look_y = rot[TL][7];
	assign neg_look_z = rot[TL][8];
	assign trans_right = tr[0]; assign trans_up = tr[1]; assign trans_look = tr[2];

	// The three translation units run in lock step.
	a_trans_sync: assert property (@(posedge clk) disable iff (!arst_n)
		tv[0] == tv[1] && tv[1] == tv[2]) else $error("translation units out of step");
	// The x components of right and up stay within one in magnitude.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (right_x <= 16'sd16384 && right_x >= -16'sd16384 &&
		upv_x <= 16'sd16384 && upv_x >= -16'sd16384)) else $error("unit out of range");
	// The up normaliser hands on each item after the normaliser latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		uv |-> $past(ucv, UL)) else $error("up normaliser latency slip");

endmodule
